// File: rtl/core/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Types, constants and helpers shared by the CC/CV charge controller.
// ----------------------------------------------------------------------------
package ccc_pkg;

  // Charge stage, one-hot
  typedef enum logic [7:0] {
    ST_PRE         = 8'b0000_0001,
    ST_CC          = 8'b0000_0010,
    ST_CV          = 8'b0000_0100,
    ST_FULL        = 8'b0000_1000,
    ST_OVERCURRENT = 8'b0001_0000,
    ST_OVERVOLTAGE = 8'b0010_0000,
    ST_OVERTEMP    = 8'b0100_0000,
    ST_DISCONNECT  = 8'b1000_0000
  } stage_e;

  // Stage codes as seen on the port
  localparam logic [2:0] CODE_PRE         = 3'd0;
  localparam logic [2:0] CODE_CC          = 3'd1;
  localparam logic [2:0] CODE_CV          = 3'd2;
  localparam logic [2:0] CODE_FULL        = 3'd3;
  localparam logic [2:0] CODE_OVERCURRENT = 3'd4;
  localparam logic [2:0] CODE_OVERVOLTAGE = 3'd5;
  localparam logic [2:0] CODE_OVERTEMP    = 3'd6;
  localparam logic [2:0] CODE_DISCONNECT  = 3'd7;

  // LED colors
  localparam logic [1:0] LED_BLUE  = 2'd0;
  localparam logic [1:0] LED_GREEN = 2'd1;
  localparam logic [1:0] LED_RED   = 2'd2;

  // Config register indexes
  localparam logic [2:0] CFG_PRECHARGE_EXIT = 3'd0;
  localparam logic [2:0] CFG_CV_TARGET      = 3'd1;
  localparam logic [2:0] CFG_FULL_CURRENT   = 3'd2;
  localparam logic [2:0] CFG_OVERTEMP       = 3'd3;
  localparam logic [2:0] CFG_DISCONNECT     = 3'd4;

  // Config reset values
  localparam logic        [15:0] RST_PRECHARGE_EXIT = 16'd6200;
  localparam logic        [15:0] RST_CV_TARGET      = 16'd8150;
  localparam logic        [15:0] RST_FULL_CURRENT   = 16'd40;
  localparam logic signed [8:0]  RST_OVERTEMP       = 9'sd50;
  localparam logic signed [8:0]  RST_DISCONNECT     = 9'sd70;

  // Duty
  localparam logic [9:0]  DUTY_START = 10'd200;
  localparam logic [10:0] STEP_S     = 11'd1;
  localparam logic [10:0] STEP_M     = 11'd3;
  localparam logic [10:0] STEP_L     = 11'd6;

  // CC current bands (mA)
  localparam logic [15:0] CUR_BAND_0 = 16'd100;
  localparam logic [15:0] CUR_BAND_1 = 16'd200;
  localparam logic [15:0] CUR_BAND_2 = 16'd340;
  localparam logic [15:0] CUR_BAND_3 = 16'd360;
  localparam logic [15:0] CUR_BAND_4 = 16'd450;
  localparam logic [15:0] CUR_BAND_5 = 16'd600;
  localparam logic [15:0] CUR_OVER   = 16'd700;

  // CV windows around the target (mV)
  localparam logic [16:0] CV_WIN_NEAR = 17'd5;
  localparam logic [16:0] CV_WIN_FAR  = 17'd50;

  typedef struct packed {
    logic [9:0] duty;
    logic [2:0] stage;
    logic       pwm_running;
    logic [1:0] led;
  } result_t;

  function automatic logic [2:0] stage_code(stage_e s);
    logic [2:0] c;
    case (s)
      ST_PRE:         c = CODE_PRE;
      ST_CC:          c = CODE_CC;
      ST_CV:          c = CODE_CV;
      ST_FULL:        c = CODE_FULL;
      ST_OVERCURRENT: c = CODE_OVERCURRENT;
      ST_OVERVOLTAGE: c = CODE_OVERVOLTAGE;
      ST_OVERTEMP:    c = CODE_OVERTEMP;
      ST_DISCONNECT:  c = CODE_DISCONNECT;
      default:        c = CODE_PRE;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] led_code(stage_e s);
    logic [1:0] c;
    case (s)
      ST_PRE, ST_CC, ST_CV: c = LED_BLUE;
      ST_FULL:              c = LED_GREEN;
      default:              c = LED_RED;
    endcase
    return c;
  endfunction

  function automatic logic [10:0] duty_down(logic [10:0] d, logic [10:0] by);
    return (d > by) ? (d - by) : 11'd0;
  endfunction

endpackage

// File: rtl/core/cc_cv_charge_controller_unit.sv
// ----------------------------------------------------------------------------
// cc_cv_charge_controller_unit
// CC/CV battery charge controller: one control sample in, one result out.
// ----------------------------------------------------------------------------
// Takes one sample (voltage, current, temperature) and returns the new PWM
// duty, charge stage, PWM-run flag and LED color. The stage/duty update is
// combinational compare and small-add logic on the stage, duty and PWM-run
// registers, so a new sample can be accepted every cycle unless stalled.
// Results leave through an output register backed by one skid entry: input
// is stalled only while both hold results. Fault stages (overcurrent,
// overvoltage, over-temperature, disconnect) and PWM-off latch until reset.
// Write config registers only while idle; the block does not enforce this.

module cc_cv_charge_controller_unit #(
  parameter int DUTY_MAX = 999
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // sample in
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        voltage_mv_i,
  input  logic [15:0]        current_ma_i,
  input  logic signed [8:0]  temperature_c_i,
  // result out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [9:0]         duty_ticks_o,
  output logic [2:0]         stage_o,
  output logic               pwm_running_o,
  output logic [1:0]         led_color_o
);

  localparam logic [9:0]  DutyClamp   = (DUTY_MAX > 1023) ? 10'd1023 : 10'(DUTY_MAX);
  localparam logic [10:0] DutyClamp11 = {1'b0, DutyClamp};

  // config registers
  logic        [15:0] precharge_exit_q;
  logic        [15:0] cv_target_q;
  logic        [15:0] full_current_q;
  logic signed [8:0]  overtemp_q;
  logic signed [8:0]  disconnect_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precharge_exit_q <= ccc_pkg::RST_PRECHARGE_EXIT;
      cv_target_q      <= ccc_pkg::RST_CV_TARGET;
      full_current_q   <= ccc_pkg::RST_FULL_CURRENT;
      overtemp_q       <= ccc_pkg::RST_OVERTEMP;
      disconnect_q     <= ccc_pkg::RST_DISCONNECT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ccc_pkg::CFG_PRECHARGE_EXIT: precharge_exit_q <= cfg_data_i;
        ccc_pkg::CFG_CV_TARGET:      cv_target_q      <= cfg_data_i;
        ccc_pkg::CFG_FULL_CURRENT:   full_current_q   <= cfg_data_i;
        ccc_pkg::CFG_OVERTEMP:       overtemp_q       <= $signed(cfg_data_i[8:0]);
        ccc_pkg::CFG_DISCONNECT:     disconnect_q     <= $signed(cfg_data_i[8:0]);
        default: ;
      endcase
    end
  end

  // handshake
  logic             out_valid_q, skid_valid_q;
  ccc_pkg::result_t out_q, skid_q, res;
  logic             in_accept, out_take;

  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;

  // controller state
  ccc_pkg::stage_e stage_q, stage_d, stage_pre;
  logic [9:0]      duty_q, duty_d;
  logic            pwm_on_q, pwm_on_d;

  logic [16:0] v17, t17;
  logic [10:0] d11, d_adj;
  logic        temp_hot, temp_disc;

  assign v17 = {1'b0, voltage_mv_i};
  assign t17 = {1'b0, cv_target_q};
  assign d11 = {1'b0, duty_q};

  assign temp_hot  = (temperature_c_i > overtemp_q) && (temperature_c_i <= disconnect_q);
  assign temp_disc = temperature_c_i > disconnect_q;

  always_comb begin
    stage_pre = stage_q;
    if (stage_q == ccc_pkg::ST_PRE && voltage_mv_i > precharge_exit_q) begin
      stage_pre = ccc_pkg::ST_CC;
    end

    stage_d = stage_pre;
    d_adj   = d11;
    case (stage_pre)
      ccc_pkg::ST_PRE: begin
        d_adj = {1'b0, ccc_pkg::DUTY_START};
      end
      ccc_pkg::ST_CC: begin
        if (voltage_mv_i > cv_target_q) begin
          stage_d = ccc_pkg::ST_CV;
        end
        if (current_ma_i < ccc_pkg::CUR_BAND_0) begin
          d_adj = d11 + ccc_pkg::STEP_L;
        end else if (current_ma_i < ccc_pkg::CUR_BAND_1) begin
          d_adj = d11 + ccc_pkg::STEP_M;
        end else if (current_ma_i < ccc_pkg::CUR_BAND_2) begin
          d_adj = d11 + ccc_pkg::STEP_S;
        end else if (current_ma_i < ccc_pkg::CUR_BAND_3) begin
          d_adj = d11;
        end else if (current_ma_i < ccc_pkg::CUR_BAND_4) begin
          d_adj = ccc_pkg::duty_down(d11, ccc_pkg::STEP_S);
        end else if (current_ma_i < ccc_pkg::CUR_BAND_5) begin
          d_adj = ccc_pkg::duty_down(d11, ccc_pkg::STEP_M);
        end else if (current_ma_i < ccc_pkg::CUR_OVER) begin
          d_adj = ccc_pkg::duty_down(d11, ccc_pkg::STEP_L);
        end else begin
          stage_d = ccc_pkg::ST_OVERCURRENT;
          d_adj   = 11'd0;
        end
      end
      ccc_pkg::ST_CV: begin
        if (current_ma_i < full_current_q) begin
          stage_d = ccc_pkg::ST_FULL;
        end
        // windows in 17 bits so target +/- offset never wraps
        if ((v17 + ccc_pkg::CV_WIN_FAR > t17) && (v17 <= t17)) begin
          d_adj = d11 + ccc_pkg::STEP_S;
        end else if ((v17 > t17) && (v17 <= t17 + ccc_pkg::CV_WIN_NEAR)) begin
          d_adj = d11;
        end else if ((v17 > t17 + ccc_pkg::CV_WIN_NEAR) &&
                     (v17 <= t17 + ccc_pkg::CV_WIN_FAR)) begin
          d_adj = ccc_pkg::duty_down(d11, ccc_pkg::STEP_S);
        end else if (v17 > t17 + ccc_pkg::CV_WIN_FAR) begin
          stage_d = ccc_pkg::ST_OVERVOLTAGE;
          d_adj   = 11'd0;
        end else begin
          d_adj = {1'b0, ccc_pkg::DUTY_START};
        end
      end
      ccc_pkg::ST_FULL: begin
        d_adj = 11'd0;
      end
      default: begin
        d_adj = d11;
      end
    endcase

    duty_d = (d_adj > DutyClamp11) ? DutyClamp : d_adj[9:0];

    pwm_on_d = pwm_on_q;
    if (temp_hot) begin
      stage_d  = ccc_pkg::ST_OVERTEMP;
      pwm_on_d = 1'b0;
    end else if (temp_disc) begin
      stage_d  = ccc_pkg::ST_DISCONNECT;
      pwm_on_d = 1'b0;
    end

    res.duty        = duty_d;
    res.stage       = ccc_pkg::stage_code(stage_d);
    res.pwm_running = pwm_on_d;
    res.led         = ccc_pkg::led_code(stage_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= ccc_pkg::ST_PRE;
      duty_q   <= ccc_pkg::DUTY_START;
      pwm_on_q <= 1'b1;
    end else if (in_accept) begin
      stage_q  <= stage_d;
      duty_q   <= duty_d;
      pwm_on_q <= pwm_on_d;
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign duty_ticks_o  = out_q.duty;
  assign stage_o       = out_q.stage;
  assign pwm_running_o = out_q.pwm_running;
  assign led_color_o   = out_q.led;

`ifndef SYNTH
  // skid entry only ever backs a held output
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without output valid");

  // PWM-off latches until reset
  a_pwm_off_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pwm_on_q |=> !pwm_on_q)
    else $error("PWM restarted without reset");

  // fault stages are left only through reset
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q == ccc_pkg::ST_OVERCURRENT || stage_q == ccc_pkg::ST_OVERVOLTAGE ||
     stage_q == ccc_pkg::ST_OVERTEMP || stage_q == ccc_pkg::ST_DISCONNECT) |=>
    (stage_q == ccc_pkg::ST_OVERCURRENT || stage_q == ccc_pkg::ST_OVERVOLTAGE ||
     stage_q == ccc_pkg::ST_OVERTEMP || stage_q == ccc_pkg::ST_DISCONNECT))
    else $error("left a fault stage");

  // PWM stopped means a temperature fault is shown in red
  a_pwm_off_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.pwm_running) |->
    (out_q.led == ccc_pkg::LED_RED &&
     (out_q.stage == ccc_pkg::CODE_OVERTEMP || out_q.stage == ccc_pkg::CODE_DISCONNECT)))
    else $error("PWM off without temperature fault");

  a_duty_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.duty <= DutyClamp))
    else $error("duty above maximum");
`endif

endmodule
